@@ design/ceg_pkg.sv @@
// ----------------------------------------------------------------------------
// ceg_pkg: shared types and constants
// Table selects, widths and the command/status bundles between the
// controller and the datapath of the entropy gain block.
// ----------------------------------------------------------------------------
package ceg_pkg;

   localparam int LVL_W   = 2;            // level field width
   localparam int CLS_W   = 2;            // class field width
   localparam int DIV_W   = 2;            // divisions register width
   localparam int CCNT_W  = 3;            // class_count register width
   localparam int CNT_W   = 16;           // count width, saturating
   localparam int FRAC_W  = 16;           // log2 fraction bits
   localparam int K_W     = 4;            // leading-one position width
   localparam int LOG_W   = K_W + FRAC_W;
   localparam int MANT_W  = 31;           // Q1.30 mantissa
   localparam int TERM_W  = CNT_W + LOG_W;
   localparam int ACC_W   = 50;
   localparam int OUT_W   = 48;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int IDX_W   = 2 * LVL_W + CLS_W;   // joint table address
   localparam int SQ_W    = 4;                   // squaring step counter

   localparam logic [CSR_IDX_W-1:0] REG_DIVISIONS   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS_COUNT = 8'd1;

   localparam logic [DIV_W-1:0]  DIVISIONS_RST   = 2'd2;
   localparam logic [CCNT_W-1:0] CLASS_COUNT_RST = 3'd2;

   typedef enum logic [2:0] {
      TBL_JOINT,
      TBL_PAIR,
      TBL_FC,
      TBL_SC,
      TBL_F,
      TBL_S
   } tbl_type;

   typedef struct packed {
      logic        sample_ld;
      logic        upd;
      logic        walk_rd;
      logic        walk_ld;
      logic        sq;
      logic        mul;
      logic        acc;
      logic        acc_clr;
      logic        out_ld;
      logic        clr;
      tbl_type     tbl;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic last;
   } sts_type;

endpackage

@@ design/ceg_ctrl.sv @@
// ----------------------------------------------------------------------------
// ceg_ctrl: sequencer
// Runs the count update (read, then write back) and, on the last word, walks every table
// entry through the shared n*log2(n) unit, then hands off the result.
// ----------------------------------------------------------------------------
module ceg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ceg_pkg::sts_type  sts,
   output ceg_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_UPD, S_RD, S_LD, S_SQ, S_MUL, S_ACC, S_FIN
   } state_type;

   state_type                    state_ff, state_in;
   ceg_pkg::tbl_type             tbl_ff, tbl_in;
   logic [ceg_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [ceg_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [ceg_pkg::IDX_W-1:0]    last_idx;
   ceg_pkg::tbl_type             tbl_next;
   logic                         slot_free;

   always_comb begin
      unique case (tbl_ff)
         ceg_pkg::TBL_JOINT: begin last_idx = 6'd63; tbl_next = ceg_pkg::TBL_PAIR; end
         ceg_pkg::TBL_PAIR:  begin last_idx = 6'd15; tbl_next = ceg_pkg::TBL_FC;   end
         ceg_pkg::TBL_FC:    begin last_idx = 6'd15; tbl_next = ceg_pkg::TBL_SC;   end
         ceg_pkg::TBL_SC:    begin last_idx = 6'd15; tbl_next = ceg_pkg::TBL_F;    end
         ceg_pkg::TBL_F:     begin last_idx = 6'd3;  tbl_next = ceg_pkg::TBL_S;    end
         default:            begin last_idx = 6'd3;  tbl_next = ceg_pkg::TBL_JOINT; end
      endcase
   end

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      tbl_in        = tbl_ff;
      idx_in        = idx_ff;
      sq_in         = sq_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      cmd.tbl       = tbl_ff;
      cmd.idx       = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.sample_ld = 1'b1;
               state_in      = S_UPD;
            end
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (sts.last) begin
               cmd.acc_clr = 1'b1;
               tbl_in      = ceg_pkg::TBL_JOINT;
               idx_in      = '0;
               state_in    = S_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_LD;
         end
         S_LD: begin
            cmd.walk_ld = 1'b1;
            sq_in       = '0;
            state_in    = S_SQ;
         end
         S_SQ: begin
            cmd.sq = 1'b1;
            sq_in  = sq_ff + 1'b1;
            if (sq_ff == '1) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (idx_ff == last_idx) begin
               idx_in = '0;
               if (tbl_ff == ceg_pkg::TBL_S) begin
                  state_in = S_FIN;
               end else begin
                  tbl_in   = tbl_next;
                  state_in = S_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            // wait for the output register to drain
            if (slot_free) begin
               cmd.out_ld    = 1'b1;
               cmd.clr       = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tbl_ff        <= ceg_pkg::TBL_JOINT;
         idx_ff        <= '0;
         sq_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tbl_ff        <= tbl_in;
         idx_ff        <= idx_in;
         sq_ff         <= sq_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

@@ design/ceg_dp.sv @@
// ----------------------------------------------------------------------------
// ceg_dp: datapath
// Count tables, configuration registers, the iterative n*log2(n) unit and
// the two signed accumulators with the output register.
// ----------------------------------------------------------------------------
module ceg_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ceg_pkg::cmd_type                  cmd,
   output ceg_pkg::sts_type                  sts,
   input  logic                              csr_valid,
   input  logic [ceg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ceg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [ceg_pkg::LVL_W-1:0]         first_level,
   input  logic [ceg_pkg::LVL_W-1:0]         second_level,
   input  logic [ceg_pkg::CLS_W-1:0]         class_label,
   input  logic                              last,
   output logic [ceg_pkg::OUT_W-1:0]         gain_first,
   output logic [ceg_pkg::OUT_W-1:0]         gain_second
);

   localparam int CNT_W  = ceg_pkg::CNT_W;
   localparam int MANT_W = ceg_pkg::MANT_W;
   localparam int ACC_W  = ceg_pkg::ACC_W;
   localparam int OUT_W  = ceg_pkg::OUT_W;
   localparam int IDX_W  = ceg_pkg::IDX_W;
   localparam int LVL_W  = ceg_pkg::LVL_W;
   localparam int CLS_W  = ceg_pkg::CLS_W;
   localparam int PAIR_W = 2 * LVL_W;
   localparam int LC_W   = LVL_W + CLS_W;
   localparam int JDEPTH = 1 << IDX_W;
   localparam int PDEPTH = 1 << PAIR_W;
   localparam int CDEPTH = 1 << LC_W;
   localparam int LDEPTH = 1 << LVL_W;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:OUT_W-1] == '0 || v[ACC_W-1:OUT_W-1] == '1) begin
         sat_out = v[OUT_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // configuration
   logic [ceg_pkg::DIV_W-1:0]  div_ff;
   logic [ceg_pkg::CCNT_W-1:0] ccnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= ceg_pkg::DIVISIONS_RST;
         ccnt_ff <= ceg_pkg::CLASS_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ceg_pkg::REG_DIVISIONS:   div_ff  <= csr_wdata[ceg_pkg::DIV_W-1:0];
            ceg_pkg::REG_CLASS_COUNT: ccnt_ff <= csr_wdata[ceg_pkg::CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // sample register
   logic [LVL_W-1:0] a_ff, b_ff;
   logic [CLS_W-1:0] c_ff;
   logic             last_ff, hit_ff, hit;

   assign hit = (first_level <= div_ff) && (second_level <= div_ff) &&
                ({1'b0, class_label} < ccnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else if (cmd.sample_ld) begin
         last_ff <= last;
         hit_ff  <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_ld) begin
         a_ff <= first_level;
         b_ff <= second_level;
         c_ff <= class_label;
      end
   end

   assign sts.last = last_ff;

   // joint table: memory with per-entry valid bits
   logic [CNT_W-1:0] joint_mem [JDEPTH];
   logic [JDEPTH-1:0] jvld_ff;
   logic [IDX_W-1:0] j_raddr, j_waddr;
   logic [CNT_W-1:0] jrd_ff, jval;
   logic             jrd_vld_ff;

   assign j_raddr = cmd.walk_rd ? cmd.idx : {first_level, second_level, class_label};
   assign j_waddr = {a_ff, b_ff, c_ff};
   assign jval    = jrd_vld_ff ? jrd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.sample_ld || cmd.walk_rd) begin
         jrd_ff <= joint_mem[j_raddr];
      end
      if (cmd.upd && hit_ff) begin
         joint_mem[j_waddr] <= sat_inc(jval);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         jvld_ff    <= '0;
         jrd_vld_ff <= 1'b0;
      end else begin
         if (cmd.sample_ld || cmd.walk_rd) begin
            jrd_vld_ff <= jvld_ff[j_raddr];
         end
         if (cmd.upd && hit_ff) begin
            jvld_ff[j_waddr] <= 1'b1;
         end
      end
   end

   // small tables in flops, one read address each
   logic [CNT_W-1:0] pair_ff [PDEPTH];
   logic [CNT_W-1:0] fc_ff   [CDEPTH];
   logic [CNT_W-1:0] sc_ff   [CDEPTH];
   logic [CNT_W-1:0] f_ff    [LDEPTH];
   logic [CNT_W-1:0] s_ff    [LDEPTH];
   logic [PAIR_W-1:0] pair_a;
   logic [LC_W-1:0]   fc_a, sc_a;
   logic [LVL_W-1:0]  f_a, s_a;
   logic [CNT_W-1:0]  pair_rd, fc_rd, sc_rd, f_rd, s_rd;

   assign pair_a  = cmd.walk_rd ? cmd.idx[PAIR_W-1:0] : {a_ff, b_ff};
   assign fc_a    = cmd.walk_rd ? cmd.idx[LC_W-1:0]   : {a_ff, c_ff};
   assign sc_a    = cmd.walk_rd ? cmd.idx[LC_W-1:0]   : {b_ff, c_ff};
   assign f_a     = cmd.walk_rd ? cmd.idx[LVL_W-1:0]  : a_ff;
   assign s_a     = cmd.walk_rd ? cmd.idx[LVL_W-1:0]  : b_ff;
   assign pair_rd = pair_ff[pair_a];
   assign fc_rd   = fc_ff[fc_a];
   assign sc_rd   = sc_ff[sc_a];
   assign f_rd    = f_ff[f_a];
   assign s_rd    = s_ff[s_a];

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         pair_ff <= '{default: '0};
         fc_ff   <= '{default: '0};
         sc_ff   <= '{default: '0};
         f_ff    <= '{default: '0};
         s_ff    <= '{default: '0};
      end else if (cmd.upd && hit_ff) begin
         pair_ff[pair_a] <= sat_inc(pair_rd);
         fc_ff[fc_a]     <= sat_inc(fc_rd);
         sc_ff[sc_a]     <= sat_inc(sc_rd);
         f_ff[f_a]       <= sat_inc(f_rd);
         s_ff[s_a]       <= sat_inc(s_rd);
      end
   end

   // walk: pick entry and decide whether it is in use
   logic [CNT_W-1:0] small_ff;
   logic             use_ff, in_use;
   logic [CNT_W-1:0] small_sel;
   logic [LVL_W-1:0] wi, wj;
   logic [CLS_W-1:0] wm;

   always_comb begin
      small_sel = '0;
      in_use    = 1'b0;
      wi        = '0;
      wj        = '0;
      wm        = '0;
      unique case (cmd.tbl)
         ceg_pkg::TBL_JOINT: begin
            {wi, wj, wm} = cmd.idx;
            in_use = (wi <= div_ff) && (wj <= div_ff) && ({1'b0, wm} < ccnt_ff);
         end
         ceg_pkg::TBL_PAIR: begin
            {wi, wj}  = cmd.idx[PAIR_W-1:0];
            small_sel = pair_rd;
            in_use    = (wi <= div_ff) && (wj <= div_ff);
         end
         ceg_pkg::TBL_FC: begin
            {wi, wm}  = cmd.idx[LC_W-1:0];
            small_sel = fc_rd;
            in_use    = (wi <= div_ff) && ({1'b0, wm} < ccnt_ff);
         end
         ceg_pkg::TBL_SC: begin
            {wi, wm}  = cmd.idx[LC_W-1:0];
            small_sel = sc_rd;
            in_use    = (wi <= div_ff) && ({1'b0, wm} < ccnt_ff);
         end
         ceg_pkg::TBL_F: begin
            wi        = cmd.idx[LVL_W-1:0];
            small_sel = f_rd;
            in_use    = (wi <= div_ff);
         end
         ceg_pkg::TBL_S: begin
            wi        = cmd.idx[LVL_W-1:0];
            small_sel = s_rd;
            in_use    = (wi <= div_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_rd) begin
         small_ff <= small_sel;
         use_ff   <= in_use;
      end
   end

   // n*log2(n): leading one, then one squaring per cycle
   logic [CNT_W-1:0]            n, n_ff;
   logic [ceg_pkg::K_W-1:0]     k, k_ff;
   logic [MANT_W-1:0]           x_ff;
   logic [ceg_pkg::FRAC_W-1:0]  frac_ff;
   logic [2*MANT_W-1:0]         prod;
   logic [MANT_W:0]             sq;
   logic [ceg_pkg::TERM_W-1:0]  term_ff;

   assign n    = (cmd.tbl == ceg_pkg::TBL_JOINT) ? jval : small_ff;
   assign prod = x_ff * x_ff;
   assign sq   = prod[2*MANT_W-1:MANT_W-1];

   always_comb begin
      k = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (n[i]) begin
            k = ceg_pkg::K_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_ld) begin
         n_ff    <= n;
         k_ff    <= k;
         x_ff    <= {{(MANT_W-CNT_W){1'b0}}, n} << (5'(MANT_W-1) - {1'b0, k});
         frac_ff <= '0;
      end else if (cmd.sq) begin
         // square >= 2 gives a one bit and is halved
         x_ff    <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
         frac_ff <= {frac_ff[ceg_pkg::FRAC_W-2:0], sq[MANT_W]};
      end
      if (cmd.mul) begin
         term_ff <= n_ff * {k_ff, frac_ff};
      end
   end

   // accumulators
   logic signed [ACC_W-1:0] acc1_ff, acc2_ff, term_s;
   logic [OUT_W-1:0]        g1_ff, g2_ff;

   assign term_s = ACC_W'(term_ff);

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc1_ff <= '0;
         acc2_ff <= '0;
      end else if (cmd.acc && use_ff) begin
         case (cmd.tbl)
            ceg_pkg::TBL_JOINT: begin
               acc1_ff <= acc1_ff + term_s;
               acc2_ff <= acc2_ff + term_s;
            end
            ceg_pkg::TBL_PAIR: begin
               acc1_ff <= acc1_ff - term_s;
               acc2_ff <= acc2_ff - term_s;
            end
            ceg_pkg::TBL_FC: acc2_ff <= acc2_ff - term_s;
            ceg_pkg::TBL_SC: acc1_ff <= acc1_ff - term_s;
            ceg_pkg::TBL_F:  acc2_ff <= acc2_ff + term_s;
            ceg_pkg::TBL_S:  acc1_ff <= acc1_ff + term_s;
            default: ;
         endcase
      end
      if (cmd.out_ld) begin
         g1_ff <= sat_out(acc1_ff);
         g2_ff <= sat_out(acc2_ff);
      end
   end

   assign gain_first  = g1_ff;
   assign gain_second = g2_ff;

endmodule

@@ design/contingency_entropy_gain_top.sv @@
// ----------------------------------------------------------------------------
// contingency_entropy_gain_top: conditional information gain from counts
// Counts (first level, second level, class) samples into contingency
// tables and, on the last sample, reports two n*log2(n) gain sums.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per sample; tlast marks the final sample of a set.
//   Each word is read from the tables, then written back; req_tready is
//   low during the write back.
//   On a word with tlast, the 120 table entries are walked through a shared
//   n*log2(n) unit one after another (read, leading one, 16 squarings,
//   multiply, accumulate) before rsp_tvalid rises. The squaring loop of
//   that unit takes most of the walk.
//   rsp channel: one word with both gains; it sits in an output register, so
//   new samples are taken while it waits. If the receiver still holds the
//   previous result when a walk ends, the block waits before loading it.
//   After each result all count tables are cleared.
//   csr channel: always ready; write only while no sample is in flight.
//   Reset: counts cleared at once, divisions = 2, class_count = 2.
// ----------------------------------------------------------------------------
module contingency_entropy_gain_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // first_level, second_level, class_label
   input  logic                             req_tlast,  // last
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [95:0]                      rsp_tdata,  // gain_first, gain_second
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ceg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ceg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ceg_pkg::cmd_type cmd;
   ceg_pkg::sts_type sts;
   logic [ceg_pkg::OUT_W-1:0] gain_first, gain_second;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {gain_second, gain_first};

   ceg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ceg_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .first_level  (req_tdata[1:0]),
      .second_level (req_tdata[3:2]),
      .class_label  (req_tdata[5:4]),
      .last         (req_tlast),
      .gain_first   (gain_first),
      .gain_second  (gain_second)
   );

endmodule

@@ design/ceg_checker.sv @@
// ----------------------------------------------------------------------------
// ceg_checker: port-level checks
// Timing relations between the sample and result channels of the top level.
// ----------------------------------------------------------------------------
module ceg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // a held result stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // each accepted word holds off the next one in the cycle after it
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted on back-to-back cycles");

   // a word without last never raises a result right away
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result after a non-final word");

   // a result only appears at the end of a walk, while input is held off
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while idle");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind contingency_entropy_gain_top ceg_checker u_ceg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
